/* rtl/rotate_scale_rgb565_blitter_macros.svh */
// ----------------------------------------------------------------------------
// Rotate/scale blitter assertion macros
// Clocked property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef ROTATE_SCALE_RGB565_BLITTER_MACROS_SVH
`define ROTATE_SCALE_RGB565_BLITTER_MACROS_SVH

// check on every rising edge, skipped while reset is held
`define RSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every rising edge, reset included
`define RSB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/rsb_pkg.sv */
// ----------------------------------------------------------------------------
// rsb_pkg
// Types, constants and helpers of the rotate/scale RGB565 blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package rsb_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int DIM_BITS  = $clog2(MAX_DIM);      // counters and coordinates
  localparam int DIMW      = DIM_BITS + 1;         // holds MAX_DIM itself
  localparam int ADDR_BITS = 24;
  localparam int ACC_BITS  = 28;
  localparam int FRAC_BITS = 16;
  localparam int STRIDE_W  = 15;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH   = 3'd0,
    CFG_SRC_HEIGHT  = 3'd1,
    CFG_ROTATION    = 3'd2,
    CFG_INV_SCALE   = 3'd3,
    CFG_DISP_WIDTH  = 3'd4,
    CFG_DISP_HEIGHT = 3'd5,
    CFG_DEST_BASE   = 3'd6,
    CFG_LINE_STRIDE = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_PIXEL = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [12:0]           src_width;
    logic [12:0]           src_height;
    rot_t                  rotation;
    logic [ACC_BITS-1:0]   inv_scale_q16;
    logic [12:0]           disp_width;
    logic [12:0]           disp_height;
    logic [ADDR_BITS-1:0]  dest_base;
    logic [STRIDE_W-1:0]   line_stride;
  } cfg_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic                 write_valid;
    logic [ADDR_BITS-1:0] write_offset;
    logic [15:0]          color;
    logic                 fetch_valid;
    logic [ADDR_BITS-1:0] fetch_index;
    logic                 frame_done;
  } out_item_t;

  // walker command: everything but the source index, which the back end builds
  typedef struct packed {
    logic                 write_valid;
    logic [ADDR_BITS-1:0] write_offset;
    logic [15:0]          color;
    logic                 fetch_valid;
    logic [DIM_BITS-1:0]  tx;
    logic [DIM_BITS-1:0]  ty;
    logic                 frame_done;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // force a dimension register into 1..MAX_DIM
  function automatic logic [DIMW-1:0] clamp_dim(input logic [12:0] v);
    logic [DIMW-1:0] r;
    if (v == 13'd0) begin
      r = DIMW'(1);
    end else if ({1'b0, v} > 14'(MAX_DIM)) begin
      r = DIMW'(MAX_DIM);
    end else begin
      r = DIMW'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/rotate_scale_rgb565_blitter.sv */
// ----------------------------------------------------------------------------
// rotate_scale_rgb565_blitter
// Nearest-neighbor rotate/scale blitter from RGB888 source to RGB565 target.
// ----------------------------------------------------------------------------
// Usage:
//   Program the window, scale, rotation and framebuffer placement through the
//   cfg channel (valid/ready, always ready) while no transaction is pending.
//   Push a start item (opcode 0) to begin a frame; its result carries the
//   first source fetch index. Answer each fetch with a pixel item (opcode 1)
//   carrying that pixel's RGB888 bytes; its result carries the framebuffer
//   write and the next fetch, or frame_done on the last pixel.
//   Every accepted item yields exactly one result on the pop side.
// Timing:
//   One item per cycle sustained while the pop side keeps up. A result passes
//   through the command queue, the rotate stage and the row-times-width
//   multiply stage before it reaches the result queue.
//   A stalled pop side fills the four-entry result queue, then the
//   four-entry command queue, and then full goes high.
// Reset:
//   Synchronous, active low. Queues empty, no frame active, registers at
//   their default values (1x1 window, unit scale, no rotation).
// ----------------------------------------------------------------------------
`default_nettype none

module rotate_scale_rgb565_blitter (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                push,
  output logic                                     full,
  input  wire rsb_pkg::in_item_t                   in_data,
  output logic                                     empty,
  input  wire logic                                pop,
  output rsb_pkg::out_item_t                       out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rsb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rsb_pkg::CFG_DATA_W-1:0]      cfg_data
);

  rsb_pkg::cfg_t      cfg_r;
  rsb_pkg::cmd_t      front_cmd, queue_cmd;
  rsb_pkg::q_status_t cmd_status;
  logic               front_push, back_pop, in_accept;

  assign cfg_ready = 1'b1;
  assign full      = cmd_status.full;
  assign in_accept = push && !cmd_status.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width     <= 13'd1;
      cfg_r.src_height    <= 13'd1;
      cfg_r.rotation      <= rsb_pkg::ROT_0;
      cfg_r.inv_scale_q16 <= rsb_pkg::ACC_BITS'(65536);
      cfg_r.disp_width    <= 13'd1;
      cfg_r.disp_height   <= 13'd1;
      cfg_r.dest_base     <= '0;
      cfg_r.line_stride   <= rsb_pkg::STRIDE_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      unique case (rsb_pkg::cfg_idx_t'(cfg_index))
        rsb_pkg::CFG_SRC_WIDTH:   cfg_r.src_width     <= cfg_data[12:0];
        rsb_pkg::CFG_SRC_HEIGHT:  cfg_r.src_height    <= cfg_data[12:0];
        rsb_pkg::CFG_ROTATION:    cfg_r.rotation      <= rsb_pkg::rot_t'(cfg_data[1:0]);
        rsb_pkg::CFG_INV_SCALE:   cfg_r.inv_scale_q16 <= cfg_data[rsb_pkg::ACC_BITS-1:0];
        rsb_pkg::CFG_DISP_WIDTH:  cfg_r.disp_width    <= cfg_data[12:0];
        rsb_pkg::CFG_DISP_HEIGHT: cfg_r.disp_height   <= cfg_data[12:0];
        rsb_pkg::CFG_DEST_BASE:   cfg_r.dest_base     <= cfg_data[rsb_pkg::ADDR_BITS-1:0];
        rsb_pkg::CFG_LINE_STRIDE: cfg_r.line_stride   <= cfg_data[rsb_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  rsb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_accept (in_accept),
    .in_item   (in_data),
    .cmd       (front_cmd),
    .cmd_push  (front_push)
  );

  rsb_cmd_queue u_cmd_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .push_data (front_cmd),
    .pop       (back_pop),
    .pop_data  (queue_cmd),
    .status    (cmd_status)
  );

  rsb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd_status (cmd_status),
    .cmd        (queue_cmd),
    .cmd_pop    (back_pop),
    .out_empty  (empty),
    .out_pop    (pop),
    .out_item   (out_data)
  );

endmodule

`default_nettype wire

/* rtl/rsb_front.sv */
// ----------------------------------------------------------------------------
// rsb_front
// Raster walker: accepts items, steps position and source accumulators and
// emits one command per item into the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rsb_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rsb_pkg::cfg_t     cfg,
  input  wire logic              in_accept,
  input  wire rsb_pkg::in_item_t in_item,
  output rsb_pkg::cmd_t          cmd,
  output logic                   cmd_push
);

  logic [rsb_pkg::DIM_BITS-1:0]  col_count_r, col_count_nxt;
  logic [rsb_pkg::DIM_BITS-1:0]  row_count_r, row_count_nxt;
  logic [rsb_pkg::ACC_BITS-1:0]  src_col_acc_r, src_col_acc_nxt;
  logic [rsb_pkg::ACC_BITS-1:0]  src_row_acc_r, src_row_acc_nxt;
  logic [rsb_pkg::ADDR_BITS-1:0] row_offset_r, row_offset_nxt;
  logic                          frame_active_r, frame_active_nxt;

  logic [rsb_pkg::DIMW-1:0]      disp_w, disp_h;
  logic [rsb_pkg::DIMW-1:0]      col_inc, row_inc;
  logic [rsb_pkg::ACC_BITS:0]    col_sum, row_sum;

  assign disp_w  = rsb_pkg::clamp_dim(cfg.disp_width);
  assign disp_h  = rsb_pkg::clamp_dim(cfg.disp_height);
  assign col_inc = {1'b0, col_count_r} + rsb_pkg::DIMW'(1);
  assign row_inc = {1'b0, row_count_r} + rsb_pkg::DIMW'(1);
  assign col_sum = {1'b0, src_col_acc_r} + {1'b0, cfg.inv_scale_q16};
  assign row_sum = {1'b0, src_row_acc_r} + {1'b0, cfg.inv_scale_q16};

  always_comb begin
    col_count_nxt    = col_count_r;
    row_count_nxt    = row_count_r;
    src_col_acc_nxt  = src_col_acc_r;
    src_row_acc_nxt  = src_row_acc_r;
    row_offset_nxt   = row_offset_r;
    frame_active_nxt = frame_active_r;
    cmd              = '0;
    cmd_push         = in_accept;

    if (in_accept) begin
      if (rsb_pkg::opcode_t'(in_item.opcode) == rsb_pkg::OP_START) begin
        col_count_nxt    = '0;
        row_count_nxt    = '0;
        src_col_acc_nxt  = '0;
        src_row_acc_nxt  = '0;
        row_offset_nxt   = cfg.dest_base;
        frame_active_nxt = 1'b1;
        cmd.fetch_valid  = 1'b1;
      end else if (frame_active_r) begin
        cmd.write_valid  = 1'b1;
        cmd.write_offset = row_offset_r +
                           rsb_pkg::ADDR_BITS'({col_count_r, 1'b0});
        cmd.color        = {in_item.red[7:3], in_item.green[7:2], in_item.blue[7:3]};
        cmd.fetch_valid  = 1'b1;
        if (col_inc < disp_w) begin
          col_count_nxt   = col_inc[rsb_pkg::DIM_BITS-1:0];
          // saturate at the top of the Q12.16 range
          src_col_acc_nxt = col_sum[rsb_pkg::ACC_BITS] ? '1
                                                       : col_sum[rsb_pkg::ACC_BITS-1:0];
        end else if (row_inc < disp_h) begin
          col_count_nxt   = '0;
          src_col_acc_nxt = '0;
          row_count_nxt   = row_inc[rsb_pkg::DIM_BITS-1:0];
          src_row_acc_nxt = row_sum[rsb_pkg::ACC_BITS] ? '1
                                                       : row_sum[rsb_pkg::ACC_BITS-1:0];
          row_offset_nxt  = row_offset_r + rsb_pkg::ADDR_BITS'(cfg.line_stride);
        end else begin
          frame_active_nxt = 1'b0;
          cmd.fetch_valid  = 1'b0;
          cmd.frame_done   = 1'b1;
        end
      end
      cmd.tx = src_col_acc_nxt[rsb_pkg::ACC_BITS-1 -: rsb_pkg::DIM_BITS];
      cmd.ty = src_row_acc_nxt[rsb_pkg::ACC_BITS-1 -: rsb_pkg::DIM_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r    <= '0;
      row_count_r    <= '0;
      src_col_acc_r  <= '0;
      src_row_acc_r  <= '0;
      row_offset_r   <= '0;
      frame_active_r <= 1'b0;
    end else begin
      col_count_r    <= col_count_nxt;
      row_count_r    <= row_count_nxt;
      src_col_acc_r  <= src_col_acc_nxt;
      src_row_acc_r  <= src_row_acc_nxt;
      row_offset_r   <= row_offset_nxt;
      frame_active_r <= frame_active_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/rsb_cmd_queue.sv */
// ----------------------------------------------------------------------------
// rsb_cmd_queue
// Short FIFO of walker commands between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rsb_cmd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire rsb_pkg::cmd_t  push_data,
  input  wire logic           pop,
  output rsb_pkg::cmd_t       pop_data,
  output rsb_pkg::q_status_t  status
);

  rsb_pkg::cmd_t                 mem_r [rsb_pkg::CMD_DEPTH];
  logic [rsb_pkg::CMD_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [rsb_pkg::CMD_CNT_W-1:0] count_r, count_nxt;

  assign status.full  = (count_r == rsb_pkg::CMD_CNT_W'(rsb_pkg::CMD_DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + rsb_pkg::CMD_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - rsb_pkg::CMD_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + rsb_pkg::CMD_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + rsb_pkg::CMD_PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/rsb_back.sv */
// ----------------------------------------------------------------------------
// rsb_back
// Source index pipeline: clamp and rotate the coordinates, multiply the row
// by the source width, add the column and queue the finished result.
// ----------------------------------------------------------------------------
`default_nettype none

module rsb_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rsb_pkg::cfg_t      cfg,
  input  wire rsb_pkg::q_status_t cmd_status,
  input  wire rsb_pkg::cmd_t      cmd,
  output logic                    cmd_pop,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output rsb_pkg::out_item_t      out_item
);

  localparam int DB = rsb_pkg::DIM_BITS;
  localparam int DW = rsb_pkg::DIMW;
  localparam int AB = rsb_pkg::ADDR_BITS;

  // stage 1: rotated coordinates
  logic                 s1_v_r;
  rsb_pkg::cmd_t        s1_cmd_r;
  logic [DB-1:0]        s1_row_r, s1_col_r;
  logic [DW-1:0]        s1_w_r;
  // stage 2: row product
  logic                 s2_v_r;
  rsb_pkg::cmd_t        s2_cmd_r;
  logic [DB+DW-1:0]     s2_prod_r;
  logic [DB-1:0]        s2_col_r;

  logic [DW-1:0]        w, h, tw, th, w_m1, h_m1, tw_m1, th_m1;
  logic [DB-1:0]        txc, tyc, row, col;
  logic                 quarter;

  rsb_pkg::out_item_t            oq_r [rsb_pkg::OUT_DEPTH];
  rsb_pkg::out_item_t            oq_wdata;
  logic [rsb_pkg::OUT_PTR_W-1:0] oq_wr_r, oq_rd_r;
  logic [rsb_pkg::OUT_CNT_W-1:0] oq_cnt_r, oq_cnt_nxt;
  logic [rsb_pkg::OUT_CNT_W:0]   committed;
  logic                          oq_push, oq_pop;

  assign w       = rsb_pkg::clamp_dim(cfg.src_width);
  assign h       = rsb_pkg::clamp_dim(cfg.src_height);
  assign quarter = cfg.rotation[0];
  assign tw      = quarter ? h : w;
  assign th      = quarter ? w : h;
  assign w_m1    = w - DW'(1);
  assign h_m1    = h - DW'(1);
  assign tw_m1   = tw - DW'(1);
  assign th_m1   = th - DW'(1);
  assign txc     = ({1'b0, cmd.tx} > tw_m1) ? tw_m1[DB-1:0] : cmd.tx;
  assign tyc     = ({1'b0, cmd.ty} > th_m1) ? th_m1[DB-1:0] : cmd.ty;

  always_comb begin
    unique case (cfg.rotation)
      rsb_pkg::ROT_90: begin
        col = tyc;
        row = h_m1[DB-1:0] - txc;
      end
      rsb_pkg::ROT_180: begin
        col = w_m1[DB-1:0] - txc;
        row = h_m1[DB-1:0] - tyc;
      end
      rsb_pkg::ROT_270: begin
        col = w_m1[DB-1:0] - tyc;
        row = txc;
      end
      default: begin
        col = txc;
        row = tyc;
      end
    endcase
  end

  // reserve an output slot for every item in flight before taking another
  assign committed = {1'b0, oq_cnt_r} + (rsb_pkg::OUT_CNT_W+1)'(s1_v_r)
                   + (rsb_pkg::OUT_CNT_W+1)'(s2_v_r);
  assign cmd_pop   = !cmd_status.empty &&
                     (committed < (rsb_pkg::OUT_CNT_W+1)'(rsb_pkg::OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_cmd_r <= cmd;
      s1_row_r <= cmd.fetch_valid ? row : '0;
      s1_col_r <= cmd.fetch_valid ? col : '0;
      s1_w_r   <= w;
    end
    if (s1_v_r) begin
      s2_cmd_r  <= s1_cmd_r;
      s2_prod_r <= (DB+DW)'(s1_row_r) * (DB+DW)'(s1_w_r);
      s2_col_r  <= s1_col_r;
    end
  end

  always_comb begin
    oq_wdata.write_valid  = s2_cmd_r.write_valid;
    oq_wdata.write_offset = s2_cmd_r.write_offset;
    oq_wdata.color        = s2_cmd_r.color;
    oq_wdata.fetch_valid  = s2_cmd_r.fetch_valid;
    oq_wdata.fetch_index  = s2_prod_r[AB-1:0] + AB'(s2_col_r);
    oq_wdata.frame_done   = s2_cmd_r.frame_done;
  end

  assign oq_push   = s2_v_r;
  assign oq_pop    = out_pop && !out_empty;
  assign out_empty = (oq_cnt_r == '0);
  assign out_item  = oq_r[oq_rd_r];

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (oq_push && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + rsb_pkg::OUT_CNT_W'(1);
    end else if (oq_pop && !oq_push) begin
      oq_cnt_nxt = oq_cnt_r - rsb_pkg::OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wr_r] <= oq_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      s1_v_r <= cmd_pop;
      s2_v_r <= s1_v_r;
      if (oq_push) begin
        oq_wr_r <= oq_wr_r + rsb_pkg::OUT_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + rsb_pkg::OUT_PTR_W'(1);
      end
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/rsb_checker.sv */
// ----------------------------------------------------------------------------
// rsb_checker
// Port-level checks of the blitter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rotate_scale_rgb565_blitter_macros.svh"

module rsb_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               empty,
  input wire logic               pop,
  input wire rsb_pkg::out_item_t out_data
);

  logic shown;
  logic done_ok;
  logic no_stray;

  assign shown    = !empty;
  assign done_ok  = out_data.write_valid && !out_data.fetch_valid;
  assign no_stray = (out_data.write_offset == '0) && (out_data.color == '0) &&
                    !out_data.frame_done;

  // reset drains every queued result
  `RSB_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> empty, "results left after reset")

  // a waiting result holds until popped
  `RSB_ASSERT(a_hold, (shown && !pop) |=> (shown && $stable(out_data)), "result changed")

  // the last write of a frame requests no further fetch
  `RSB_ASSERT(a_done_shape, (shown && out_data.frame_done) |-> done_ok, "bad frame end")

  // an absent write leaves its offset, color and frame_done at zero
  `RSB_ASSERT(a_zero_fields, (shown && !out_data.write_valid) |-> no_stray, "stray write fields")

endmodule

bind rotate_scale_rgb565_blitter rsb_checker u_rsb_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);

`default_nettype wire
